FILE: design/ils_pkg.sv
// Shared types and constants for the integer literal scanner.
package ils_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_COMMENT = 3'd1,
		MODE_SIGN    = 3'd2,
		MODE_ZERO    = 3'd3,
		MODE_HEX     = 3'd4,
		MODE_DEC     = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ST_NUMBER = 2'd0,
		ST_NOTNUM = 2'd1,
		ST_END    = 2'd2
	} status_t;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_X_LOWER = 8'h78;
	localparam logic [7:0] CH_A_UPPER = 8'h41;
	localparam logic [7:0] CH_F_UPPER = 8'h46;
	localparam logic [7:0] CH_A_LOWER = 8'h61;
	localparam logic [7:0] CH_F_LOWER = 8'h66;

	localparam int HEX_SHIFT = 4; // radix 0x10

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	typedef struct packed {
		mode_t       mode;
		logic [31:0] acc;
		logic        neg;
	} scan_state_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] value;
		logic [7:0]  offending;
	} result_t;

	// Up to two results produced by one input transaction.
	typedef struct packed {
		logic    any;
		logic    two;
		result_t r0;
		result_t r1;
	} result_pair_t;

endpackage

FILE: design/ils_step.sv
// Per-byte scanner update: next scan state and the results one transaction produces.
module ils_step (
	input  logic                kind,
	input  logic [7:0]          text_byte,
	input  ils_pkg::scan_state_t cur,
	output ils_pkg::scan_state_t nxt,
	output ils_pkg::result_pair_t res
);

	typedef struct packed {
		ils_pkg::scan_state_t st;
		logic                 bad;
	} start_t;

	function automatic logic is_blank(input logic [7:0] b);
		is_blank = (b == ils_pkg::CH_SPACE) || (b == ils_pkg::CH_LF) ||
		           (b == ils_pkg::CH_CR) || (b == ils_pkg::CH_TAB) ||
		           (b == ils_pkg::CH_COMMA);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		is_digit = (b >= ils_pkg::CH_ZERO) && (b <= ils_pkg::CH_NINE);
	endfunction

	function automatic ils_pkg::scan_state_t begin_digits(input logic [7:0] b);
		ils_pkg::scan_state_t s;
		s.acc  = {28'd0, b[3:0]};
		s.neg  = 1'b0;
		s.mode = (b == ils_pkg::CH_ZERO) ? ils_pkg::MODE_ZERO : ils_pkg::MODE_DEC;
		return s;
	endfunction

	function automatic start_t start_token(input logic [7:0] b);
		start_t t;
		t.st.mode = ils_pkg::MODE_IDLE;
		t.st.acc  = 32'd0;
		t.st.neg  = 1'b0;
		t.bad     = 1'b0;
		if (is_blank(b)) begin
			t.bad = 1'b0;
		end else if (b == ils_pkg::CH_HASH) begin
			t.st.mode = ils_pkg::MODE_COMMENT;
		end else if ((b == ils_pkg::CH_PLUS) || (b == ils_pkg::CH_MINUS)) begin
			t.st.mode = ils_pkg::MODE_SIGN;
			t.st.neg  = (b == ils_pkg::CH_MINUS);
		end else if (is_digit(b)) begin
			t.st.mode = begin_digits(b).mode;
			t.st.acc  = begin_digits(b).acc;
		end else begin
			t.bad = 1'b1;
		end
		return t;
	endfunction

	logic        hex_ok;
	logic [3:0]  hex_val;
	logic [31:0] dec_acc;
	logic [31:0] hex_acc;
	logic [31:0] signed_val;
	start_t      st_tok;
	ils_pkg::result_t num_res;
	ils_pkg::result_t bad_res;
	ils_pkg::result_t end_res;
	ils_pkg::result_t sign_res;
	ils_pkg::scan_state_t idle_st;

	always_comb begin
		hex_ok  = 1'b0;
		hex_val = text_byte[3:0];
		if (is_digit(text_byte)) begin
			hex_ok = 1'b1;
		end else if (((text_byte >= ils_pkg::CH_A_UPPER) && (text_byte <= ils_pkg::CH_F_UPPER)) ||
		             ((text_byte >= ils_pkg::CH_A_LOWER) && (text_byte <= ils_pkg::CH_F_LOWER))) begin
			hex_ok  = 1'b1;
			hex_val = text_byte[3:0] + 4'd9;
		end
	end

	assign dec_acc    = (cur.acc << 3) + (cur.acc << 1) + {28'd0, text_byte[3:0]};
	assign hex_acc    = {cur.acc[31-ils_pkg::HEX_SHIFT:0], hex_val};
	assign signed_val = cur.neg ? (32'd0 - cur.acc) : cur.acc;
	assign st_tok     = start_token(text_byte);

	assign num_res  = '{status: ils_pkg::ST_NUMBER, value: signed_val, offending: 8'd0};
	assign bad_res  = '{status: ils_pkg::ST_NOTNUM, value: 32'd0, offending: text_byte};
	assign end_res  = '{status: ils_pkg::ST_END, value: 32'd0, offending: 8'd0};
	assign sign_res = '{status: ils_pkg::ST_NOTNUM, value: 32'd0, offending: 8'd0};
	assign idle_st  = '{mode: ils_pkg::MODE_IDLE, acc: 32'd0, neg: 1'b0};

	always_comb begin
		nxt     = cur;
		res.any = 1'b0;
		res.two = 1'b0;
		res.r0  = end_res;
		res.r1  = end_res;
		if (kind) begin
			nxt     = idle_st;
			res.any = 1'b1;
			case (cur.mode) inside
				ils_pkg::MODE_ZERO, ils_pkg::MODE_HEX, ils_pkg::MODE_DEC: begin
					res.two = 1'b1;
					res.r0  = num_res;
				end
				ils_pkg::MODE_SIGN: begin
					res.two = 1'b1;
					res.r0  = sign_res;
				end
				default: begin
					res.two = 1'b0;
				end
			endcase
		end else begin
			case (cur.mode)
				ils_pkg::MODE_COMMENT: begin
					if ((text_byte == ils_pkg::CH_LF) || (text_byte == ils_pkg::CH_CR))
						nxt.mode = ils_pkg::MODE_IDLE;
				end
				ils_pkg::MODE_SIGN: begin
					if (is_digit(text_byte)) begin
						nxt.mode = begin_digits(text_byte).mode;
						nxt.acc  = begin_digits(text_byte).acc;
					end else begin
						// sign lost; a byte that can start a token starts one
						nxt     = st_tok.st;
						res.any = 1'b1;
						res.r0  = bad_res;
					end
				end
				ils_pkg::MODE_ZERO, ils_pkg::MODE_DEC: begin
					if ((cur.mode == ils_pkg::MODE_ZERO) && (text_byte == ils_pkg::CH_X_LOWER)) begin
						nxt.mode = ils_pkg::MODE_HEX;
					end else if (is_digit(text_byte)) begin
						nxt.mode = ils_pkg::MODE_DEC;
						nxt.acc  = dec_acc;
					end else begin
						nxt     = st_tok.st;
						res.any = 1'b1;
						res.two = st_tok.bad;
						res.r0  = num_res;
						res.r1  = bad_res;
					end
				end
				ils_pkg::MODE_HEX: begin
					if (hex_ok) begin
						nxt.acc = hex_acc;
					end else begin
						nxt     = st_tok.st;
						res.any = 1'b1;
						res.two = st_tok.bad;
						res.r0  = num_res;
						res.r1  = bad_res;
					end
				end
				default: begin
					nxt     = st_tok.st;
					res.any = st_tok.bad;
					res.r0  = bad_res;
				end
			endcase
		end
	end

endmodule

FILE: design/integer_literal_scanner.sv
// Integer literal scanner top level: input stage, scan state, result buffer and output register.
// Accepts one text byte (or end marker) per cycle. A byte sits one cycle in the input
// register, where the scan state is updated and its one or two results, if any, are written
// as one entry into a 4-entry result buffer; results leave through an output register
// one per cycle while m_tready allows it. An item that yields two results is sent as
// two output transfers; input stalls only when the result buffer is full.
module integer_literal_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] text_byte
	input  logic        s_tuser,  // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [31:0] number_value, [39:32] offending_byte
	output logic [1:0]  m_tuser,  // [1:0] status
	output logic        m_tlast   // last_of_run
);

	localparam int AW = ils_pkg::FIFO_AW;

	logic                  valid_s1;
	logic                  kind_s1;
	logic [7:0]            byte_s1;
	ils_pkg::scan_state_t  scan_q;
	ils_pkg::scan_state_t  scan_nxt;
	ils_pkg::result_pair_t step_res;

	ils_pkg::result_pair_t fifo_q [ils_pkg::FIFO_DEPTH];
	logic [AW-1:0]         wr_ptr_q;
	logic [AW-1:0]         rd_ptr_q;
	logic [AW:0]           cnt_q;
	logic                  head_sub_q;

	logic                  out_valid_q;
	ils_pkg::result_t      out_res_q;
	logic                  out_last_q;

	logic                  fifo_full;
	logic                  adv;
	logic                  wr;
	logic                  load;
	logic                  pop;
	ils_pkg::result_pair_t head;

	ils_step u_step (
		.kind      (kind_s1),
		.text_byte (byte_s1),
		.cur       (scan_q),
		.nxt       (scan_nxt),
		.res       (step_res)
	);

	assign fifo_full = (cnt_q == (AW+1)'(ils_pkg::FIFO_DEPTH));
	assign s_tready  = !valid_s1 || !fifo_full;
	assign adv       = valid_s1 && !fifo_full;
	assign wr        = adv && step_res.any;
	assign head      = fifo_q[rd_ptr_q];
	assign load      = (!out_valid_q || m_tready) && (cnt_q != '0);
	assign pop       = load && (head_sub_q || !head.two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '{mode: ils_pkg::MODE_IDLE, acc: 32'd0, neg: 1'b0};
		end else if (adv) begin
			scan_q <= scan_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			fifo_q[wr_ptr_q] <= step_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			cnt_q      <= '0;
			head_sub_q <= 1'b0;
		end else begin
			if (wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!wr && pop)
				cnt_q <= cnt_q - 1'b1;
			if (load)
				head_sub_q <= !pop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= (cnt_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_res_q  <= head_sub_q ? head.r1 : head.r0;
			out_last_q <= head_sub_q || !head.two;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_res_q.offending, out_res_q.value};
	assign m_tuser  = out_res_q.status;
	assign m_tlast  = out_last_q;

endmodule

FILE: design/ils_checker.sv
// Port-level checks for the integer literal scanner, bound to the top level.
module ils_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("output transaction changed while stalled");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ils_pkg::ST_END) |-> m_tlast)
		else $error("end of input not marked last");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ils_pkg::ST_NUMBER) |-> (m_tdata[31:0] == 32'd0))
		else $error("nonzero value on non-number result");

	a_offending_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ils_pkg::ST_NOTNUM) |-> (m_tdata[39:32] == 8'd0))
		else $error("nonzero offending byte outside not-a-number result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ils_pkg::ST_NUMBER) || (m_tuser == ils_pkg::ST_NOTNUM) ||
		(m_tuser == ils_pkg::ST_END))
		else $error("undefined status code");

endmodule

bind integer_literal_scanner ils_checker u_ils_checker (.*);

FILE: verif/testbench.sv
// Self-checking testbench for the integer literal scanner stream block.
`timescale 1ns / 100ps

module testbench;

	localparam logic [31:0] DEC_BASE = 32'd10;
	localparam logic [31:0] HEX_BASE = 32'h10;

	typedef struct packed {
		ils_pkg::status_t status;
		logic [31:0]      value;
		logic [7:0]       offending;
		logic             last;
	} scan_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;  // [7:0] text_byte
	logic        s_tuser = 1'b0;   // [0] kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;          // [31:0] number_value, [39:32] offending_byte
	logic [1:0]  m_tuser;          // [1:0] status
	logic        m_tlast;

	scan_result_t   expected_results[$];
	ils_pkg::mode_t lex_mode = ils_pkg::MODE_IDLE;
	logic [31:0]    lex_acc = '0;
	logic           lex_neg = 1'b0;
	int             sent_items = 0;
	int             error_count = 0;
	int             stall_left = 0;
	bit             idle_enable = 1'b1;

	integer_literal_scanner u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit is_blank_char(input logic [7:0] b);
		return b == ils_pkg::CH_SPACE || b == ils_pkg::CH_LF || b == ils_pkg::CH_CR ||
			b == ils_pkg::CH_TAB || b == ils_pkg::CH_COMMA;
	endfunction

	function automatic bit is_digit_char(input logic [7:0] b);
		return b >= ils_pkg::CH_ZERO && b <= ils_pkg::CH_NINE;
	endfunction

	function automatic int hex_digit_value(input logic [7:0] b);
		if (is_digit_char(b)) return int'(b - ils_pkg::CH_ZERO);
		if (b >= ils_pkg::CH_A_UPPER && b <= ils_pkg::CH_F_UPPER)
			return int'(b - ils_pkg::CH_A_UPPER) + 10;
		if (b >= ils_pkg::CH_A_LOWER && b <= ils_pkg::CH_F_LOWER)
			return int'(b - ils_pkg::CH_A_LOWER) + 10;
		return -1;
	endfunction

	task automatic push_result(input ils_pkg::status_t st, input logic [31:0] v,
		input logic [7:0] off);
		scan_result_t r;
		r.status = st;
		r.value = v;
		r.offending = off;
		r.last = 1'b0;
		expected_results.push_back(r);
	endtask

	task automatic clear_scan();
		lex_mode = ils_pkg::MODE_IDLE;
		lex_acc = '0;
		lex_neg = 1'b0;
	endtask

	task automatic open_digits(input logic [7:0] b);
		if (b == ils_pkg::CH_ZERO) begin
			lex_acc = '0;
			lex_mode = ils_pkg::MODE_ZERO;
		end else begin
			lex_acc = 32'(b - ils_pkg::CH_ZERO);
			lex_mode = ils_pkg::MODE_DEC;
		end
	endtask

	task automatic open_token(input logic [7:0] b);
		clear_scan();
		if (is_blank_char(b)) begin
		end else if (b == ils_pkg::CH_HASH) begin
			lex_mode = ils_pkg::MODE_COMMENT;
		end else if (b == ils_pkg::CH_PLUS || b == ils_pkg::CH_MINUS) begin
			lex_neg = (b == ils_pkg::CH_MINUS);
			lex_mode = ils_pkg::MODE_SIGN;
		end else if (is_digit_char(b)) begin
			open_digits(b);
		end else begin
			push_result(ils_pkg::ST_NOTNUM, '0, b);
		end
	endtask

	task automatic close_number();
		push_result(ils_pkg::ST_NUMBER, lex_neg ? 32'd0 - lex_acc : lex_acc, 8'h00);
		clear_scan();
	endtask

	// Updates the scan state for one accepted transaction and queues its results.
	task automatic predict_scan(input logic kind, input logic [7:0] b);
		int before_n;
		int h;
		scan_result_t r;
		before_n = expected_results.size();
		sent_items++;
		if (kind) begin
			if (lex_mode == ils_pkg::MODE_ZERO || lex_mode == ils_pkg::MODE_HEX ||
				lex_mode == ils_pkg::MODE_DEC)
				close_number();
			else if (lex_mode == ils_pkg::MODE_SIGN)
				push_result(ils_pkg::ST_NOTNUM, '0, 8'h00);
			clear_scan();
			push_result(ils_pkg::ST_END, '0, 8'h00);
		end else begin
			case (lex_mode)
				ils_pkg::MODE_COMMENT: begin
					if (b == ils_pkg::CH_LF || b == ils_pkg::CH_CR) lex_mode = ils_pkg::MODE_IDLE;
				end
				ils_pkg::MODE_SIGN: begin
					if (is_digit_char(b)) begin
						open_digits(b);
					end else begin
						push_result(ils_pkg::ST_NOTNUM, '0, b);
						if (is_blank_char(b) || b == ils_pkg::CH_HASH || b == ils_pkg::CH_PLUS ||
							b == ils_pkg::CH_MINUS)
							open_token(b);
						else
							clear_scan();
					end
				end
				ils_pkg::MODE_ZERO, ils_pkg::MODE_DEC: begin
					if (lex_mode == ils_pkg::MODE_ZERO && b == ils_pkg::CH_X_LOWER) begin
						lex_mode = ils_pkg::MODE_HEX;
					end else begin
						lex_mode = ils_pkg::MODE_DEC;
						if (is_digit_char(b)) begin
							lex_acc = lex_acc * DEC_BASE + 32'(b - ils_pkg::CH_ZERO);
						end else begin
							close_number();
							open_token(b);
						end
					end
				end
				ils_pkg::MODE_HEX: begin
					h = hex_digit_value(b);
					if (h >= 0) begin
						lex_acc = lex_acc * HEX_BASE + 32'(h);
					end else begin
						close_number();
						open_token(b);
					end
				end
				default: open_token(b);
			endcase
		end
		if (expected_results.size() > before_n) begin
			r = expected_results.pop_back();
			r.last = 1'b1;
			expected_results.push_back(r);
		end
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(input logic kind, input logic [7:0] b);
		if (idle_enable && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		predict_scan(kind, b);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
	endtask

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 4))
			0: return ils_pkg::CH_SPACE;
			1: return ils_pkg::CH_LF;
			2: return ils_pkg::CH_CR;
			3: return ils_pkg::CH_TAB;
			default: return ils_pkg::CH_COMMA;
		endcase
	endfunction

	function automatic logic [7:0] pick_hex_char();
		case ($urandom_range(0, 2))
			0: return ils_pkg::CH_ZERO + 8'($urandom_range(0, 9));
			1: return ils_pkg::CH_A_LOWER + 8'($urandom_range(0, 5));
			default: return ils_pkg::CH_A_UPPER + 8'($urandom_range(0, 5));
		endcase
	endfunction

	task automatic send_comment();
		logic [7:0] b;
		send_item(1'b0, ils_pkg::CH_HASH);
		repeat ($urandom_range(0, 6)) begin
			b = 8'($urandom_range(0, 255));
			if (b == ils_pkg::CH_LF || b == ils_pkg::CH_CR) b = ils_pkg::CH_SPACE;
			send_item(1'b0, b);
		end
		send_item(1'b0, $urandom_range(0, 1) ? ils_pkg::CH_LF : ils_pkg::CH_CR);
	endtask

	// Optional sign, decimal or hex digits, then a random kind of terminator.
	task automatic send_number();
		int sel;
		case ($urandom_range(0, 2))
			0: send_item(1'b0, ils_pkg::CH_PLUS);
			1: send_item(1'b0, ils_pkg::CH_MINUS);
			default: ;
		endcase
		if ($urandom_range(0, 1)) begin
			send_text("0x");
			if ($urandom_range(0, 7) == 0) begin
				repeat (8) send_item(1'b0, $urandom_range(0, 1) ? "f" : "F");
			end else begin
				repeat ($urandom_range(0, 10)) send_item(1'b0, pick_hex_char());
			end
		end else begin
			repeat ($urandom_range(1, $urandom_range(0, 3) == 0 ? 12 : 4))
				send_item(1'b0, ils_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
		end
		sel = $urandom_range(0, 15);
		if (sel < 9) send_item(1'b0, pick_blank());
		else if (sel < 11) send_comment();
		else if (sel < 13)
			send_item(1'b0, $urandom_range(0, 1) ? ils_pkg::CH_PLUS : ils_pkg::CH_MINUS);
		else if (sel < 15) send_item(1'b0, 8'($urandom_range(0, 255)));
		else send_item(1'b1, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_broken();
		case ($urandom_range(0, 2))
			0: begin
				send_item(1'b0, $urandom_range(0, 1) ? ils_pkg::CH_PLUS : ils_pkg::CH_MINUS);
				send_item($urandom_range(0, 5) == 0, 8'($urandom_range(0, 255)));
			end
			1: begin
				send_text("0x");
				send_item($urandom_range(0, 5) == 0, 8'($urandom_range(0, 255)));
			end
			default: send_item(1'b0, 8'($urandom_range(0, 255)));
		endcase
	endtask

	task automatic run_token_mix(input int target);
		int sel;
		while (sent_items < target) begin
			sel = $urandom_range(0, 19);
			if (sel < 14) send_number();
			else if (sel < 16) send_comment();
			else if (sel < 18) send_broken();
			else if (sel < 19) send_item(1'b1, 8'($urandom_range(0, 255)));
			else send_item(1'b0, pick_blank());
		end
	endtask

	task automatic test_directed();
		send_text("0x,");
		send_text("-9a");
		send_text("+q");
		send_text("-#z\n");
		send_text("0xFf\t");
		send_item(1'b0, 8'hFF);
		send_item(1'b0, 8'h00);
		send_text("07");
		send_item(1'b1, 8'h00);
		send_text("-");
		send_item(1'b1, 8'hFF);
		send_item(1'b1, 8'h00);
	endtask

	task automatic test_token_stream(input int target);
		run_token_mix(target);
	endtask

	task automatic test_byte_noise(input int target);
		while (sent_items < target)
			send_item($urandom_range(0, 31) == 0, 8'($urandom_range(0, 255)));
	endtask

	task automatic test_unthrottled(input int target);
		idle_enable = 1'b0;
		run_token_mix(target);
	endtask

	always @(negedge clk) begin
		if (idle_enable && stall_left == 0 && $urandom_range(0, 9) == 0)
			stall_left = $urandom_range(1, 17);
		if (idle_enable && stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		scan_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transaction: status %0d value %h", m_tuser, m_tdata[31:0]);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, m_tuser);
					error_count++;
				end
				if (m_tdata[31:0] !== want.value) begin
					$error("number_value: expected %h, actual %h", want.value, m_tdata[31:0]);
					error_count++;
				end
				if (m_tdata[39:32] !== want.offending) begin
					$error("offending_byte: expected %h, actual %h", want.offending,
						m_tdata[39:32]);
					error_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last_of_run: expected %0d, actual %0d", want.last, m_tlast);
					error_count++;
				end
			end
		end
	end

	initial begin
		#10ms;
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_token_stream(1250);
		test_byte_noise(1450);
		test_unthrottled(1650);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("results still expected at end: %0d", expected_results.size());
			error_count++;
		end
		if (error_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
